@@ rtl/core/mctt_pkg.sv @@
// Package for the MIDI clock tempo tracker: sizes, constants, codes and state types.
// Used by the channel interfaces, the shared divider and the top level.
`default_nettype none

package mctt_pkg;

    // History ring and time base.
    localparam int HIST_DEPTH = 16;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int TIME_BITS  = 48;
    localparam int IVL_W      = 32;
    localparam int SUM_W      = IVL_W + HIST_IDX_W;

    // Tempo arithmetic: tempo_q8 = TEMPO_NUM / mean, saturated to TEMPO_MAX.
    localparam int TEMPO_W               = 20;
    localparam logic [SUM_W-1:0] TEMPO_NUM = SUM_W'(640000000);
    localparam logic [TEMPO_W-1:0] TEMPO_MAX = {TEMPO_W{1'b1}};

    // Shared divider sizing.
    localparam int DIV_W     = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MIN_INT_W  = 20;
    localparam int MIN_HIST_W = 5;

    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST  = CFG_DATA_W'(500000);
    localparam logic [MIN_INT_W-1:0]  MIN_INT_RST  = MIN_INT_W'(1000);
    localparam logic [MIN_HIST_W-1:0] MIN_HIST_RST = MIN_HIST_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT  = 2'd0,
        CFG_MIN_INT  = 2'd1,
        CFG_MIN_HIST = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_FIRST   = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_SHORT   = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP,
        S_CLASS,
        S_CHECK,
        S_SUM,
        S_DIV_MEAN,
        S_WAIT_MEAN,
        S_DIV_TEMPO,
        S_WAIT_TEMPO,
        S_TGT_DIFF,
        S_TGT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/mctt_ifs.sv @@
// Valid/ready channel interfaces for the tempo tracker input ticks and results.
// Depends on mctt_pkg for the field widths.
`default_nettype none

interface mctt_in_if;
    logic                           valid;
    logic                           ready;
    logic [mctt_pkg::TIME_BITS-1:0] arrival_time_us;

    modport source (output valid, output arrival_time_us, input ready);
    modport sink   (input valid, input arrival_time_us, output ready);
endinterface

interface mctt_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   tick_status;
    logic                         stable_tick;
    logic [mctt_pkg::IVL_W-1:0]   mean_interval_us;
    logic [mctt_pkg::TEMPO_W-1:0] tempo_bpm_q8;
    logic                         tempo_valid;

    modport source (output valid, output tick_status, output stable_tick,
                    output mean_interval_us, output tempo_bpm_q8, output tempo_valid,
                    input ready);
    modport sink   (input valid, input tick_status, input stable_tick,
                    input mean_interval_us, input tempo_bpm_q8, input tempo_valid,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/mctt_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on mctt_pkg for its widths.
`default_nettype none

module mctt_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [mctt_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [mctt_pkg::IVL_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic [mctt_pkg::DIV_W-1:0]          o_quot
);

    logic                               r_busy;
    logic [mctt_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [mctt_pkg::IVL_W-1:0]         r_rem;
    logic [mctt_pkg::DIV_W-1:0]         r_q;
    logic [mctt_pkg::IVL_W-1:0]         r_dvs;
    logic                               r_done_seen;

    logic [mctt_pkg::IVL_W:0]           rem_sh;
    logic                               q_bit;
    logic [mctt_pkg::IVL_W:0]           rem_sub;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        rem_sh  = {r_rem, r_q[mctt_pkg::DIV_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Control: busy flag and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= mctt_pkg::DIV_CNT_W'(mctt_pkg::DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: remainder and the dividend register that fills with quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[mctt_pkg::IVL_W-1:0] : rem_sh[mctt_pkg::IVL_W-1:0];
            r_q   <= {r_q[mctt_pkg::DIV_W-2:0], q_bit};
        end
    end

    assign o_done = !r_busy && (r_cnt == {mctt_pkg::DIV_CNT_W{1'b1}}) && r_done_seen;

    // Done pulses for one cycle after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else begin
            r_done_seen <= r_busy && (r_cnt == '0);
        end
    end

    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ rtl/core/midi_clock_tempo_tracker.sv @@
// MIDI clock tempo tracker, 24 ticks per quarter note. A first, ignored or timeout tick
// goes straight to the result, as does an accepted one when too few intervals are held.
// Otherwise the held intervals (up to 16) are summed from the ring and the shared divider
// forms the mean and, for a nonzero mean, the tempo; each divider pass is a start, one
// step per quotient bit and a done. One item is in work at a time.
// Synchronous active-low reset restores the register defaults and clears history.
`default_nettype none

module midi_clock_tempo_tracker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mctt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [mctt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    mctt_in_if.sink                                   i_in,
    mctt_out_if.source                                o_res
);

    // Configuration registers.
    logic [mctt_pkg::CFG_DATA_W-1:0] r_timeout;
    logic [mctt_pkg::MIN_INT_W-1:0]  r_min_int;
    logic [mctt_pkg::MIN_HIST_W-1:0] r_min_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= mctt_pkg::TIMEOUT_RST;
            r_min_int  <= mctt_pkg::MIN_INT_RST;
            r_min_hist <= mctt_pkg::MIN_HIST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mctt_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                mctt_pkg::CFG_MIN_INT:  r_min_int  <= i_cfg_data[mctt_pkg::MIN_INT_W-1:0];
                mctt_pkg::CFG_MIN_HIST: r_min_hist <= i_cfg_data[mctt_pkg::MIN_HIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and tracker state.
    mctt_pkg::t_state                  r_state, n_state;
    logic [mctt_pkg::TIME_BITS-1:0]    r_now, n_now;
    logic [mctt_pkg::TIME_BITS-1:0]    r_gap, n_gap;
    logic [mctt_pkg::TIME_BITS-1:0]    r_last, n_last;
    logic                              r_seen, n_seen;
    logic [mctt_pkg::HIST_IDX_W-1:0]   r_widx, n_widx;
    logic [mctt_pkg::FILL_W-1:0]       r_fill, n_fill;
    logic [mctt_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic [mctt_pkg::FILL_W-1:0]       r_cnt, n_cnt;
    logic [mctt_pkg::IVL_W-1:0]        r_mean, n_mean;
    logic [mctt_pkg::TEMPO_W-1:0]      r_tempo, n_tempo;
    logic [mctt_pkg::TIME_BITS-1:0]    r_target, n_target;
    logic                              r_sched, n_sched;
    mctt_pkg::t_status                 r_status, n_status;
    logic                              r_stable, n_stable;

    // Output register.
    logic                              r_ov, n_ov;
    mctt_pkg::t_status                 r_o_status, n_o_status;
    logic                              r_o_stable, n_o_stable;
    logic [mctt_pkg::IVL_W-1:0]        r_o_mean, n_o_mean;
    logic [mctt_pkg::TEMPO_W-1:0]      r_o_tempo, n_o_tempo;

    // Interval ring memory with registered read.
    logic [mctt_pkg::IVL_W-1:0]        r_ring [mctt_pkg::HIST_DEPTH];
    logic [mctt_pkg::IVL_W-1:0]        r_rd;
    logic                              ring_we;
    logic                              rd_en;
    logic [mctt_pkg::HIST_IDX_W-1:0]   rd_addr;

    // Shared divider hookup.
    logic                              div_start;
    logic                              div_done;
    logic [mctt_pkg::DIV_W-1:0]        div_dividend;
    logic [mctt_pkg::IVL_W-1:0]        div_divisor;
    logic [mctt_pkg::DIV_W-1:0]        div_quot;

    logic                              in_xfer;

    assign i_in.ready = (r_state == mctt_pkg::S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    // The mean pass divides the sum by the fill count; the tempo pass divides the
    // tempo numerator by the mean.
    always_comb begin
        if (r_state == mctt_pkg::S_DIV_TEMPO) begin
            div_dividend = mctt_pkg::TEMPO_NUM;
            div_divisor  = r_mean;
        end else begin
            div_dividend = r_sum;
            div_divisor  = mctt_pkg::IVL_W'(r_fill);
        end
    end

    mctt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_widx] <= r_gap[mctt_pkg::IVL_W-1:0];
        end
        if (rd_en) begin
            r_rd <= r_ring[rd_addr];
        end
    end

    // Next state and datapath of the sequencer.
    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_gap      = r_gap;
        n_last     = r_last;
        n_seen     = r_seen;
        n_widx     = r_widx;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_mean     = r_mean;
        n_tempo    = r_tempo;
        n_target   = r_target;
        n_sched    = r_sched;
        n_status   = r_status;
        n_stable   = r_stable;
        n_ov       = r_ov && !o_res.ready;
        n_o_status = r_o_status;
        n_o_stable = r_o_stable;
        n_o_mean   = r_o_mean;
        n_o_tempo  = r_o_tempo;
        ring_we    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        div_start  = 1'b0;

        unique case (r_state)
            mctt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_now   = i_in.arrival_time_us;
                    n_state = mctt_pkg::S_GAP;
                end
            end

            mctt_pkg::S_GAP: begin
                n_gap   = r_now - r_last;
                n_state = mctt_pkg::S_CLASS;
            end

            // Sort the tick by its gap to the previous one.
            mctt_pkg::S_CLASS: begin
                n_stable = 1'b0;
                n_last   = r_now;
                n_seen   = 1'b1;
                priority if (!r_seen) begin
                    n_status = mctt_pkg::ST_FIRST;
                    n_state  = mctt_pkg::S_DONE;
                end else if (r_gap > mctt_pkg::TIME_BITS'(r_timeout)) begin
                    n_status = mctt_pkg::ST_TIMEOUT;
                    n_widx   = '0;
                    n_fill   = '0;
                    n_mean   = '0;
                    n_tempo  = '0;
                    n_target = '0;
                    n_sched  = 1'b0;
                    n_state  = mctt_pkg::S_DONE;
                end else if (r_gap < mctt_pkg::TIME_BITS'(r_min_int)) begin
                    n_status = mctt_pkg::ST_SHORT;
                    n_state  = mctt_pkg::S_DONE;
                end else begin
                    n_status = mctt_pkg::ST_ACCEPT;
                    ring_we  = 1'b1;
                    n_widx   = r_widx + 1'b1;
                    if (r_fill != mctt_pkg::FILL_W'(mctt_pkg::HIST_DEPTH)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state  = mctt_pkg::S_CHECK;
                end
            end

            // Too little history clears the tempo; otherwise start the ring sum.
            mctt_pkg::S_CHECK: begin
                if (mctt_pkg::MIN_HIST_W'(r_fill) < r_min_hist) begin
                    n_mean   = '0;
                    n_tempo  = '0;
                    n_target = '0;
                    n_sched  = 1'b0;
                    n_state  = mctt_pkg::S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_cnt   = mctt_pkg::FILL_W'(1);
                    n_sum   = '0;
                    n_state = mctt_pkg::S_SUM;
                end
            end

            // Accumulate one ring entry per cycle while the next one is read.
            mctt_pkg::S_SUM: begin
                n_sum = r_sum + mctt_pkg::SUM_W'(r_rd);
                if (r_cnt == r_fill) begin
                    n_state = mctt_pkg::S_DIV_MEAN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[mctt_pkg::HIST_IDX_W-1:0];
                    n_cnt   = r_cnt + 1'b1;
                end
            end

            mctt_pkg::S_DIV_MEAN: begin
                div_start = 1'b1;
                n_state   = mctt_pkg::S_WAIT_MEAN;
            end

            mctt_pkg::S_WAIT_MEAN: begin
                if (div_done) begin
                    n_mean = div_quot[mctt_pkg::IVL_W-1:0];
                    if (div_quot[mctt_pkg::IVL_W-1:0] == '0) begin
                        n_tempo  = '0;
                        n_target = '0;
                        n_sched  = 1'b0;
                        n_state  = mctt_pkg::S_DONE;
                    end else begin
                        n_state  = mctt_pkg::S_DIV_TEMPO;
                    end
                end
            end

            mctt_pkg::S_DIV_TEMPO: begin
                div_start = 1'b1;
                n_state   = mctt_pkg::S_WAIT_TEMPO;
            end

            // Saturate the tempo quotient to its field.
            mctt_pkg::S_WAIT_TEMPO: begin
                if (div_done) begin
                    if (|div_quot[mctt_pkg::DIV_W-1:mctt_pkg::TEMPO_W]) begin
                        n_tempo = mctt_pkg::TEMPO_MAX;
                    end else begin
                        n_tempo = div_quot[mctt_pkg::TEMPO_W-1:0];
                    end
                    n_state = mctt_pkg::S_TGT_DIFF;
                end
            end

            mctt_pkg::S_TGT_DIFF: begin
                n_gap   = r_now - r_target;
                n_state = mctt_pkg::S_TGT;
            end

            // Schedule the first stable tick, or advance a reached target.
            mctt_pkg::S_TGT: begin
                if (!r_sched) begin
                    n_target = r_now + mctt_pkg::TIME_BITS'(r_mean);
                    n_sched  = 1'b1;
                    n_stable = 1'b1;
                end else if (!r_gap[mctt_pkg::TIME_BITS-1]) begin
                    n_target = r_target + mctt_pkg::TIME_BITS'(r_mean);
                    n_stable = 1'b1;
                end
                n_state = mctt_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free.
            mctt_pkg::S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_stable = r_stable;
                    n_o_mean   = r_mean;
                    n_o_tempo  = r_tempo;
                    n_state    = mctt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mctt_pkg::S_IDLE;
            end
        endcase
    end

    // Control and tracker state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mctt_pkg::S_IDLE;
            r_last   <= '0;
            r_seen   <= 1'b0;
            r_widx   <= '0;
            r_fill   <= '0;
            r_mean   <= '0;
            r_tempo  <= '0;
            r_target <= '0;
            r_sched  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_seen   <= n_seen;
            r_widx   <= n_widx;
            r_fill   <= n_fill;
            r_mean   <= n_mean;
            r_tempo  <= n_tempo;
            r_target <= n_target;
            r_sched  <= n_sched;
            r_ov     <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_gap      <= n_gap;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_stable   <= n_stable;
        r_o_status <= n_o_status;
        r_o_stable <= n_o_stable;
        r_o_mean   <= n_o_mean;
        r_o_tempo  <= n_o_tempo;
    end

    assign o_res.valid            = r_ov;
    assign o_res.tick_status      = r_o_status;
    assign o_res.stable_tick      = r_o_stable;
    assign o_res.mean_interval_us = r_o_mean;
    assign o_res.tempo_bpm_q8     = r_o_tempo;
    assign o_res.tempo_valid      = (r_o_mean != '0);

    // A zero mean never leaves a target scheduled.
    a_mean_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mean == '0) |-> !r_sched)
        else $error("target scheduled without a valid mean");

    // A stable tick only comes from an accepted interval with a valid tempo.
    a_stable_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.stable_tick) |->
            (o_res.tick_status == mctt_pkg::ST_ACCEPT) && o_res.tempo_valid)
        else $error("stable tick on a result that is not an accepted interval");

    // The fill count never passes the ring depth.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mctt_pkg::FILL_W'(mctt_pkg::HIST_DEPTH))
        else $error("ring fill count beyond depth");

    // A tick transfer moves the sequencer to the gap state and takes the input ready away.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == mctt_pkg::S_GAP) && !i_in.ready)
        else $error("tick transfer did not start the sequencer");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for midi_clock_tempo_tracker: directed and random MIDI clock tick streams,
// checked against a tempo predictor kept inside the bench. Depends on mctt_pkg, the
// mctt_in_if and mctt_out_if channel interfaces and the tracker RTL.

module testbench;
    import mctt_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_status              status;
        logic                 stable;
        logic [IVL_W-1:0]     mean;
        logic [TEMPO_W-1:0]   tempo;
        logic                 valid;
    } t_tempo_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mctt_in_if  tick_if ();
    mctt_out_if res_if ();

    midi_clock_tempo_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if),
        .o_res      (res_if)
    );

    // Tracker state as the bench expects it, plus its copy of the registers.
    logic [IVL_W-1:0]      ring_ivl [HIST_DEPTH];
    logic [HIST_IDX_W-1:0] ring_wr;
    logic [FILL_W-1:0]     ring_fill;
    t_time                 last_time;
    logic                  last_seen;
    t_time                 target_time;
    logic                  target_live;
    logic [IVL_W-1:0]      mean_ivl;
    logic [TEMPO_W-1:0]    tempo_q8;
    logic [CFG_DATA_W-1:0] cf_timeout;
    logic [MIN_INT_W-1:0]  cf_min_int;
    logic [MIN_HIST_W-1:0] cf_min_hist;

    // Pending tick times and the tempo results they should produce.
    t_time         tick_times_q [$];
    t_tempo_result tempo_expect_q [$];
    t_tempo_result tempo_want;

    t_time gen_time;
    logic  tick_taken = 1'b0;
    int    err_count = 0;
    int    quiet_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_req = 0;
    int    hold_ack = 0;
    int    hold_left = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop all interval history, the last tick time, the tempo and the stable tick schedule.
    function automatic void clear_tracker();
        foreach (ring_ivl[i]) ring_ivl[i] = '0;
        ring_wr     = '0;
        ring_fill   = '0;
        last_time   = '0;
        last_seen   = 1'b0;
        target_time = '0;
        target_live = 1'b0;
        mean_ivl    = '0;
        tempo_q8    = '0;
    endfunction

    // Advance the expected tracker state by one tick and return its result.
    function automatic t_tempo_result track_tick(input t_time now);
        t_tempo_result     r;
        t_time             gap;
        t_time             lag;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  quot;
        r.status = ST_FIRST;
        r.stable = 1'b0;
        if (last_seen) begin
            gap = now - last_time;
            if (gap > cf_timeout) begin
                clear_tracker();
                r.status = ST_TIMEOUT;
            end else if (gap < cf_min_int) begin
                r.status = ST_SHORT;
            end else begin
                ring_ivl[ring_wr] = gap[IVL_W-1:0];
                ring_wr = ring_wr + 1'b1;
                if (ring_fill < HIST_DEPTH) ring_fill = ring_fill + 1'b1;
                r.status = ST_ACCEPT;
                // Mean and tempo only exist once enough intervals are held.
                if (ring_fill < cf_min_hist) begin
                    mean_ivl = '0;
                end else begin
                    sum = '0;
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        if (i < ring_fill) sum = sum + ring_ivl[i];
                    end
                    mean_ivl = IVL_W'(sum / SUM_W'(ring_fill));
                end
                if (mean_ivl == 0) begin
                    tempo_q8    = '0;
                    target_live = 1'b0;
                    target_time = '0;
                end else begin
                    quot = TEMPO_NUM / SUM_W'(mean_ivl);
                    tempo_q8 = (quot > SUM_W'(TEMPO_MAX)) ? TEMPO_MAX : quot[TEMPO_W-1:0];
                end
            end
        end
        last_time = now;
        // A short tick only moves the last time; otherwise the schedule may fire.
        if (r.status != ST_SHORT) begin
            last_seen = 1'b1;
            if (mean_ivl != 0) begin
                if (!target_live) begin
                    target_time = now + TIME_BITS'(mean_ivl);
                    target_live = 1'b1;
                    r.stable    = 1'b1;
                end else begin
                    lag = now - target_time;
                    if (!lag[TIME_BITS-1]) begin
                        target_time = target_time + TIME_BITS'(mean_ivl);
                        r.stable    = 1'b1;
                    end
                end
            end
        end
        r.mean  = mean_ivl;
        r.tempo = tempo_q8;
        r.valid = (mean_ivl != 0);
        return r;
    endfunction

    function automatic void check_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Predict at the edge where a tick transfer happens.
    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && tick_if.valid && tick_if.ready;
        if (i_rst_n && tick_if.valid && tick_if.ready)
            tempo_expect_q.push_back(track_tick(tick_if.arrival_time_us));
    end

    // Tick driver: offers queued times, with random idle cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else if (!tick_if.valid || tick_taken) begin
            if (tick_times_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                tick_if.valid           <= 1'b1;
                tick_if.arrival_time_us <= tick_times_q.pop_front();
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (tempo_expect_q.size() == 0) begin
                err_count++;
                $display("%0t: result with none expected: status %0d, mean %0d, tempo %0d",
                         $time, res_if.tick_status, res_if.mean_interval_us,
                         res_if.tempo_bpm_q8);
            end else begin
                tempo_want = tempo_expect_q.pop_front();
                check_field("tick_status", tempo_want.status, res_if.tick_status);
                check_field("stable_tick", tempo_want.stable, res_if.stable_tick);
                check_field("mean_interval_us", tempo_want.mean, res_if.mean_interval_us);
                check_field("tempo_bpm_q8", tempo_want.tempo, res_if.tempo_bpm_q8);
                check_field("tempo_valid", tempo_want.valid, res_if.tempo_valid);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TIMEOUT:  cf_timeout  = value;
            CFG_MIN_INT:  cf_min_int  = value[MIN_INT_W-1:0];
            CFG_MIN_HIST: cf_min_hist = value[MIN_HIST_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers; only called while the tracker is idle.
    task automatic set_regs(input logic [31:0] timeout, input logic [31:0] min_int,
                            input logic [31:0] min_hist);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_MIN_INT, min_int);
        write_reg(CFG_MIN_HIST, min_hist);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_at(input t_time at);
        gen_time = at;
        tick_times_q.push_back(at);
    endtask

    task automatic queue_gap(input longint unsigned gap);
        queue_at(gen_time + t_time'(gap));
    endtask

    // Wait until every tick is sent and every result has come back.
    task automatic drain();
        while (tick_times_q.size() != 0 || tick_if.valid || tempo_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly steady clock streams with jitter and tempo changes, plus noise ticks,
    // stopped-clock gaps and jumps to arbitrary times.
    task automatic queue_random(input int n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned span;
        longint unsigned base;
        longint unsigned jit;
        longint unsigned gap;
        int              roll;
        lo   = cf_min_int;
        hi   = cf_timeout;
        base = lo;
        if (hi < lo) hi = lo;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (k == 0 || roll >= 96) begin
                span = hi - lo;
                if ($urandom_range(1) == 1 && span > lo / 2 + 64) span = lo / 2 + 64;
                base = lo + ($urandom() % (span + 1));
            end
            if (roll < 6 && cf_min_int != 0) begin
                queue_gap($urandom_range(cf_min_int - 1));
            end else if (roll < 8) begin
                queue_gap(hi + 1 + $urandom_range(2000));
            end else if (roll < 10) begin
                queue_at(t_time'({$urandom(), $urandom()}));
            end else begin
                jit = base / 32;
                gap = base + ($urandom() % (jit + 1)) - jit / 2;
                if (gap < lo) gap = lo;
                if (gap > hi) gap = hi;
                queue_gap(gap);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] timeout, input logic [31:0] min_int,
                             input logic [31:0] min_hist, input int send_pct,
                             input int recv_pct, input int n, input bit hold_off);
        set_regs(timeout, min_int, min_hist);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(n);
        if (hold_off) hold_req++;
        drain();
    endtask

    // Stimulus.
    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = CFG_TIMEOUT;
        i_cfg_data              = '0;
        tick_if.valid           = 1'b0;
        tick_if.arrival_time_us = '0;
        res_if.ready            = 1'b0;
        cf_timeout              = TIMEOUT_RST;
        cf_min_int              = MIN_INT_RST;
        cf_min_hist             = MIN_HIST_RST;
        gen_time                = '0;
        clear_tracker();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: a stream across the time wrap, noise at and below the
        // minimum, a gap at the timeout and just past it, then extreme time values.
        queue_at(48'hFFFF_FFFF_B000);
        queue_gap(20833);
        queue_gap(20833);
        queue_gap(500);
        queue_gap(20333);
        queue_gap(1000);
        queue_gap(999);
        queue_gap(500000);
        queue_gap(500001);
        queue_gap(21000);
        queue_gap(21000);
        queue_gap(21000);
        queue_gap(21000);
        queue_at(48'hFFFF_FFFF_FFFF);
        queue_at(48'h0000_0000_0000);
        queue_at(48'h5555_5555_5555);
        queue_at(48'hAAAA_AAAA_AAAA);
        drain();

        // Zero timeout and zero minimum: zero gaps give a zero mean.
        set_regs(32'd0, 32'd0, 32'd0);
        queue_at(48'h0000_0000_1000);
        queue_gap(0);
        queue_gap(0);
        queue_gap(1);
        drain();

        // Widest registers; the history requirement can never be met.
        set_regs(32'hFFFF_FFFF, 32'h000F_FFFF, 32'd31);
        queue_gap(64'hFFFF_FFFF);
        queue_gap(64'h1_0000_0000);
        queue_gap(64'hF_FFFE);
        drain();

        // Minimum interval above the timeout.
        set_regs(32'd500, 32'd1000, 32'd1);
        queue_gap(700);
        queue_gap(300);
        drain();

        run_phase(32'd500000, 32'd1000, 32'd2, 0, 0, 180, 1'b1);
        run_phase(32'd30000, 32'd5000, 32'd4, 75, 0, 150, 1'b0);
        run_phase(32'd2000, 32'd1, 32'd16, 0, 75, 150, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'h000F_FFFF, 32'd1, 12, 12, 150, 1'b0);
        run_phase(32'd1, 32'd0, 32'd0, 0, 0, 120, 1'b0);
        run_phase(32'd100000, 32'd600, 32'd20, 12, 12, 100, 1'b0);
        run_phase(32'd700000, 32'd200, 32'd8, 40, 40, 150, 1'b0);
        run_phase(32'd20000, 32'd300, 32'd3, 0, 0, 120, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tempo_expect_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, tempo_expect_q.size());
        if (err_count == 0 && tempo_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
